FILE: hw/rtl/npc_pkg.sv
// Shared types and constants for the nearest palette color unit.
// No dependencies; npc_ctrl, npc_dist, the top level and the testbench import it.
package npc_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
    localparam int CHAN_W          = 8;
    localparam int COLOR_W         = 3 * CHAN_W;
    localparam int SQ_W            = 2 * CHAN_W;
    // The largest distance is 3 * 255 * 255, which fits in 18 bits.
    localparam int DIST_W          = SQ_W + 2;
    localparam int RES_W           = 8;

    typedef enum logic [0:0] {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } npc_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } npc_state_t;

    typedef struct packed {
        logic             busy;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             data_vld;
        logic [IDX_W-1:0] data_idx;
        logic             res_load;
    } npc_ctl_t;

    typedef struct packed {
        logic pipe_busy;
    } npc_stat_t;

endpackage

FILE: hw/rtl/npc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; used for the palette store.
module npc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/npc_ctrl.sv
// Scan sequencer: walks the palette addresses for one query and times the drain.
// Depends on npc_pkg.
module npc_ctrl
    import npc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      query_go,
    input  logic      res_free,
    input  npc_stat_t stat,
    output npc_ctl_t  ctl
);

    npc_state_t       state_reg, state_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic             data_vld_reg;
    logic [IDX_W-1:0] data_idx_reg;
    logic             last_addr;

    assign last_addr = (addr_reg == IDX_W'(PALETTE_ENTRIES - 1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_go)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_addr)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!data_vld_reg && !stat.pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        ctl          = '0;
        ctl.busy     = (state_reg != ST_IDLE);
        ctl.rd_en    = (state_reg == ST_SCAN);
        ctl.rd_addr  = addr_reg;
        ctl.data_vld = data_vld_reg;
        ctl.data_idx = data_idx_reg;
        ctl.res_load = (state_reg == ST_DONE) && res_free;
    end

    always_comb
    begin
        addr_next = addr_reg;
        if (state_reg == ST_SCAN)
        begin
            addr_next = last_addr ? '0 : addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            addr_reg     <= '0;
            data_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            data_vld_reg <= (state_reg == ST_SCAN);
        end
    end

    always_ff @(posedge clk)
    begin
        data_idx_reg <= addr_reg;
    end

    a_vld_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        data_vld_reg |-> $past(state_reg == ST_SCAN))
        else $error("read data flagged valid without a read in the prior cycle");

    a_scan_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ctl.rd_en) |-> (addr_reg == '0))
        else $error("palette scan did not start at entry zero");

    a_done_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (!data_vld_reg && !stat.pipe_busy))
        else $error("result offered while distance pipeline still busy");

endmodule

FILE: hw/rtl/npc_dist.sv
// Distance datapath: squared RGB distance per entry and running best tracking.
// Depends on npc_pkg.
module npc_dist
    import npc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               data_vld,
    input  logic [IDX_W-1:0]   data_idx,
    input  logic [COLOR_W-1:0] entry,
    input  logic [COLOR_W-1:0] query,
    output npc_stat_t          stat,
    output logic [IDX_W-1:0]   best_idx
);

    logic [CHAN_W-1:0] d_r, d_g, d_b;
    logic [SQ_W-1:0]   sq_r_reg, sq_g_reg, sq_b_reg;
    logic              s2_vld_reg;
    logic [IDX_W-1:0]  s2_idx_reg;
    logic [DIST_W-1:0] cand_dist;
    logic [DIST_W-1:0] best_dist_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic              better;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    assign d_r = abs_diff(query[COLOR_W-1 -: CHAN_W], entry[COLOR_W-1 -: CHAN_W]);
    assign d_g = abs_diff(query[SQ_W-1 -: CHAN_W], entry[SQ_W-1 -: CHAN_W]);
    assign d_b = abs_diff(query[CHAN_W-1:0], entry[CHAN_W-1:0]);

    // Stage one: three 8x8 squares.
    always_ff @(posedge clk)
    begin
        sq_r_reg   <= d_r * d_r;
        sq_g_reg   <= d_g * d_g;
        sq_b_reg   <= d_b * d_b;
        s2_idx_reg <= data_idx;
    end

    // Stage two: sum and compare. Only a strictly smaller distance wins,
    // so ties keep the lower index.
    assign cand_dist = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    assign better    = (cand_dist < best_dist_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg    <= 1'b0;
            best_dist_reg <= '1;
            best_idx_reg  <= '0;
        end
        else
        begin
            s2_vld_reg <= data_vld;
            if (start)
            begin
                // All ones exceeds any real distance, so entry zero always wins first.
                best_dist_reg <= '1;
                best_idx_reg  <= '0;
            end
            else if (s2_vld_reg && better)
            begin
                best_dist_reg <= cand_dist;
                best_idx_reg  <= s2_idx_reg;
            end
        end
    end

    assign stat.pipe_busy = s2_vld_reg;
    assign best_idx       = best_idx_reg;

endmodule

FILE: hw/rtl/nearest_palette_color_unit.sv
// Top level of the nearest palette color unit: stream ports, palette RAM,
// scan control, distance datapath and result register. Depends on npc_pkg,
// npc_ram, npc_ctrl and npc_dist.
//
// Usage: beats arrive on the s_ channel. s_tuser selects the kind: a write
// beat (kind 0) stores red, green and blue into the palette entry named by
// entry_index and produces no result; a write to an index at or beyond the
// palette size is dropped. A query beat (kind 1) searches the whole palette
// and produces one beat on the m_ channel carrying the index of the nearest
// entry by squared RGB distance, lowest index on a tie.
// Every palette entry must be written before the first query.
// Throughput: a query walks the palette one entry per cycle through the
// single read port of the palette RAM, so s_tready stays low through the
// scan itself, the RAM read, square and compare stages, and the result
// hand-off, which waits while the output register is still full.
// A finished result sits in the output register; while it waits, further
// writes and a new query are accepted, but a second query that finishes
// before the first result is taken holds in its last state until the
// output register frees up. Reset clears all control state and the output
// valid; palette contents are not cleared and must be rewritten.
module nearest_palette_color_unit
    import npc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
    input  logic [0:0]  s_tuser,   // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // nearest_index[7:0]
);

    logic               s_accept;
    logic               query_go;
    logic [CHAN_W-1:0]  entry_index;
    logic [COLOR_W-1:0] in_color;
    logic               ram_we;
    logic [COLOR_W-1:0] ram_rdata;
    logic [COLOR_W-1:0] qcolor_reg;
    logic               res_free;
    logic               m_tvalid_reg;
    logic [RES_W-1:0]   m_tdata_reg;
    logic [IDX_W-1:0]   best_idx;
    npc_ctl_t           ctl;
    npc_stat_t          stat;

    assign entry_index = s_tdata[7:0];
    // Packed red in the top byte, blue in the bottom byte.
    assign in_color    = {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};

    // The unit accepts nothing while a search is in flight, which keeps
    // palette writes away from the scan reads.
    assign s_tready = !ctl.busy;
    assign s_accept = s_tvalid && s_tready;
    assign query_go = s_accept && (npc_kind_t'(s_tuser[0]) == KIND_QUERY);
    assign ram_we   = s_accept && (npc_kind_t'(s_tuser[0]) == KIND_WRITE)
                      && (int'(entry_index) < PALETTE_ENTRIES);

    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            qcolor_reg <= in_color;
        end
    end

    npc_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IDX_W'(entry_index)),
        .wdata (in_color),
        .re    (ctl.rd_en),
        .raddr (ctl.rd_addr),
        .rdata (ram_rdata)
    );

    npc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .query_go (query_go),
        .res_free (res_free),
        .stat     (stat),
        .ctl      (ctl)
    );

    npc_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (query_go),
        .data_vld (ctl.data_vld),
        .data_idx (ctl.data_idx),
        .entry    (ram_rdata),
        .query    (qcolor_reg),
        .stat     (stat),
        .best_idx (best_idx)
    );

    // Output register: free when empty or being taken this cycle.
    assign res_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (ctl.res_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.res_load)
        begin
            // The full winning index is reported, as RES_W equals IDX_W.
            m_tdata_reg <= RES_W'(best_idx);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_no_write_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ctl.rd_en))
        else $error("palette write collided with a scan read");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.res_load |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over a beat not yet taken");

    a_busy_after_query: assert property (@(posedge clk) disable iff (!rst_n)
        query_go |=> (ctl.busy && ctl.rd_en))
        else $error("accepted query did not start a scan");

endmodule

FILE: tb/sv/nearest_palette_color_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for nearest_palette_color_unit: loads the palette, runs directed and random
// write/query beats and checks every nearest-index result against a local predictor.
// Depends on npc_pkg and the nearest_palette_color_unit RTL.
module nearest_palette_color_unit_tb;
    import npc_pkg::*;

    localparam int          CLK_HALF_NS    = 4;
    localparam int          RESET_CYCLES   = 8;
    localparam int          QUERY_CYCLES   = PALETTE_ENTRIES + 4;
    localparam int          TAIL_CYCLES    = QUERY_CYCLES + 40;
    localparam int          RX_HOLD_CYCLES = 1500;
    localparam int          MAX_REPORTS    = 10;
    localparam longint      RUN_LIMIT_NS   = 5_000_000;
    localparam int unsigned DIST_INIT      = 32'hffff_ffff;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
    logic [0:0]  s_tuser  = '0;   // kind[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // nearest_index[7:0]

    // Local copy of the palette, updated when a write beat is accepted.
    logic [COLOR_W-1:0] palette_model [PALETTE_ENTRIES];
    // Nearest indexes predicted for accepted queries, oldest first.
    logic [RES_W-1:0]   expected_nearest [$];

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          rx_hold_req = 1'b0;
    bit          rx_hold_ack = 1'b0;
    int          fail_count  = 0;
    int          report_count = 0;
    logic [7:0]  want_idx;

    nearest_palette_color_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    function automatic int unsigned chan_sq(input logic [7:0] a, input logic [7:0] b);
        int unsigned d;
        d = (a > b) ? (a - b) : (b - a);
        return d * d;
    endfunction

    // Full palette walk; only a strictly smaller distance replaces the best,
    // so the lowest index wins a tie.
    function automatic logic [RES_W-1:0] nearest_entry(input logic [7:0] red,
                                                      input logic [7:0] green,
                                                      input logic [7:0] blue);
        int unsigned best_dist;
        int unsigned cand_dist;
        int unsigned best_idx;
        best_dist = DIST_INIT;
        best_idx  = 0;
        for (int j = 0; j < PALETTE_ENTRIES; j++)
        begin
            cand_dist = chan_sq(red, palette_model[j][23:16])
                      + chan_sq(green, palette_model[j][15:8])
                      + chan_sq(blue, palette_model[j][7:0]);
            if (cand_dist < best_dist)
            begin
                best_dist = cand_dist;
                best_idx  = j;
            end
        end
        return best_idx[RES_W-1:0];
    endfunction

    // Offers one beat and returns in the time step of the edge that accepted it,
    // with s_tvalid still high so the next beat can follow without a gap.
    task automatic send_beat(input npc_kind_t kind, input logic [7:0] idx,
                             input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {blue, green, red, idx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (kind == KIND_WRITE)
        begin
            if (idx < PALETTE_ENTRIES)
                palette_model[idx] = {red, green, blue};
        end
        else
        begin
            expected_nearest.push_back(nearest_entry(red, green, blue));
        end
    endtask

    task automatic send_rgb(input npc_kind_t kind, input logic [7:0] idx,
                            input logic [23:0] rgb);
        send_beat(kind, idx, rgb[23:16], rgb[15:8], rgb[7:0]);
    endtask

    // Drops s_tvalid and waits until every predicted result has been taken.
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_nearest.size() != 0) @(posedge clk);
    endtask

    // Every entry must be written before the first query. The pattern toggles
    // every bit of the index and of each color component.
    task automatic test_palette_load();
        logic [7:0] i8;
        for (int i = 0; i < PALETTE_ENTRIES; i++)
        begin
            i8 = 8'(i);
            send_beat(KIND_WRITE, i8, i8, ~i8, i8 * 8'd37);
        end
    endtask

    task automatic test_extreme_colors();
        send_beat(KIND_QUERY, 8'h00, 8'h00, 8'h00, 8'h00);
        send_beat(KIND_QUERY, 8'hff, 8'hff, 8'hff, 8'hff);
        send_beat(KIND_QUERY, 8'h5a, 8'hff, 8'h00, 8'h00);
        send_beat(KIND_QUERY, 8'ha5, 8'h00, 8'hff, 8'h00);
        send_beat(KIND_QUERY, 8'h00, 8'h00, 8'h00, 8'hff);
        // Exact matches held in the first and the last entry.
        send_beat(KIND_WRITE, 8'h00, 8'hff, 8'hff, 8'hff);
        send_beat(KIND_WRITE, 8'hff, 8'h00, 8'h00, 8'h00);
        send_beat(KIND_QUERY, 8'h12, 8'h00, 8'h00, 8'h00);
        send_beat(KIND_QUERY, 8'h34, 8'hff, 8'hff, 8'hff);
    endtask

    task automatic test_tie_break();
        // Two identical entries: the lower index must win at distance zero.
        send_beat(KIND_WRITE, 8'd40, 8'd17, 8'd34, 8'd51);
        send_beat(KIND_WRITE, 8'd20, 8'd17, 8'd34, 8'd51);
        send_beat(KIND_QUERY, 8'hff, 8'd17, 8'd34, 8'd51);
        // Equal nonzero distances from two and then three different colors.
        send_beat(KIND_WRITE, 8'd60, 8'd100, 8'd100, 8'd100);
        send_beat(KIND_WRITE, 8'd50, 8'd102, 8'd100, 8'd100);
        send_beat(KIND_QUERY, 8'h00, 8'd101, 8'd100, 8'd100);
        send_beat(KIND_WRITE, 8'd30, 8'd101, 8'd100, 8'd99);
        send_beat(KIND_QUERY, 8'h80, 8'd101, 8'd100, 8'd100);
        // Overwriting an entry replaces its old color.
        send_beat(KIND_WRITE, 8'd30, 8'd0, 8'd0, 8'd1);
        send_beat(KIND_QUERY, 8'h01, 8'd101, 8'd100, 8'd100);
    endtask

    // The receiver stops for a long stretch while queries keep coming: the first
    // result parks in the output register, a second query finishes behind it
    // and the block then has to hold off its input.
    task automatic test_output_backpressure();
        wait_results_done();
        tx_idle_pct = 0;
        rx_hold_req = ~rx_hold_req;
        send_beat(KIND_QUERY, 8'h00, 8'd200, 8'd10, 8'd90);
        send_beat(KIND_WRITE, 8'd77, 8'd201, 8'd11, 8'd90);
        send_beat(KIND_QUERY, 8'h00, 8'd200, 8'd10, 8'd90);
        send_beat(KIND_WRITE, 8'd78, 8'd3, 8'd250, 8'd4);
        send_beat(KIND_QUERY, 8'h00, 8'd3, 8'd250, 8'd4);
        send_beat(KIND_QUERY, 8'h00, 8'd128, 8'd128, 8'd128);
    endtask

    // Writes and queries, many landing on or near stored colors so ties and
    // exact matches happen often, plus fully random colors and pure extremes.
    task automatic test_random_mix(input int n_items, input int tx_pct, input int rx_pct);
        int unsigned pick;
        logic [7:0]  idx;
        logic [23:0] rgb;
        logic [23:0] stored;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < n_items; n++)
        begin
            pick   = $urandom_range(99);
            idx    = 8'($urandom_range(255));
            rgb    = 24'($urandom_range(24'hff_ffff));
            stored = palette_model[$urandom_range(PALETTE_ENTRIES - 1)];
            if (pick < 30)
                send_rgb(KIND_WRITE, idx, rgb);
            else if (pick < 50)
                send_rgb(KIND_WRITE, idx, stored ^ (rgb & 24'h01_0101));
            else if (pick < 65)
                send_rgb(KIND_QUERY, idx, rgb);
            else if (pick < 85)
                send_rgb(KIND_QUERY, idx, stored ^ (rgb & 24'h03_0303));
            else
                send_beat(KIND_QUERY, idx, {8{rgb[0]}}, {8{rgb[1]}}, {8{rgb[2]}});
        end
    endtask

    // Receiver side: random ready, or a long hold each time one is requested.
    initial
    begin : rx_ready_gen
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req != rx_hold_ack)
            begin
                hold_left   = RX_HOLD_CYCLES;
                rx_hold_ack = rx_hold_req;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Compares each result beat with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_nearest.size() == 0)
            begin
                fail_count++;
                report_count++;
                if (report_count <= MAX_REPORTS)
                    $display("%0t: result beat %0d with no query pending", $realtime, m_tdata);
            end
            else
            begin
                want_idx = expected_nearest.pop_front();
                if (m_tdata !== want_idx)
                begin
                    fail_count++;
                    report_count++;
                    if (report_count <= MAX_REPORTS)
                        $display("%0t: nearest_index mismatch, expected %0d, got %0d",
                                 $realtime, want_idx, m_tdata);
                end
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 30;
        rx_idle_pct = 71;
        test_palette_load();
        test_extreme_colors();
        test_tie_break();
        test_output_backpressure();
        test_random_mix(40, 30, 71);
        test_random_mix(40, 71, 30);
        test_random_mix(40, 0, 0);

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule
